[rtl/radial_brush_mask_sampler_top_assert.svh]
// assertion macros for the mask sampler
`ifndef RADIAL_BRUSH_MASK_SAMPLER_TOP_ASSERT_SVH
`define RADIAL_BRUSH_MASK_SAMPLER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only out of reset
`define RBMS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rbms: check failed");
// checked at every edge, reset included
`define RBMS_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("rbms: reset check failed");
`else
`define RBMS_ASSERT(lbl, prop)
`define RBMS_ASSERT_RST(lbl, prop)
`endif
`endif

[rtl/rbms_pkg.sv]
package rbms_pkg;

	localparam int IDX_W    = 8;
	localparam int SIZE_W   = 9;
	localparam int QUO_W    = 25;
	localparam int COORD_W  = 17;
	localparam int R2_W     = 18;
	localparam int DENS_W   = 17;
	localparam int OUT_W    = 8;

	localparam int DIV_LAT  = QUO_W;
	localparam int RAD_LAT  = 3;
	localparam int KER_LAT  = 21;
	localparam int PIPE_LAT = DIV_LAT + RAD_LAT + KER_LAT;

	localparam logic [DENS_W-1:0] Q16_ONE = 17'd65536;
	localparam longint unsigned EINV_Q30 = 64'd395007542;

	typedef enum logic [1:0] {
		KIND_GAUSS  = 2'd0,
		KIND_PARZEN = 2'd1,
		KIND_CIRCLE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic {
		CFG_KIND = 1'b0,
		CFG_SIZE = 1'b1
	} cfg_idx_t;

	// exp(-t), t and result in q16; used to build the gaussian table
	function automatic logic [DENS_W-1:0] exp_neg_q16(input longint unsigned t);
		longint unsigned whole;
		longint unsigned fr;
		longint unsigned term;
		longint unsigned v;
		longint unsigned i;
		longint          sum;
		whole = t >> 16;
		fr    = t & 64'hFFFF;
		term  = 64'd1 << 30;
		sum   = longint'(term);
		if (whole >= 24)
			return '0;
		// alternating taylor series, term i = term(i-1) * fr / (65536 * i)
		term = (term * fr) >> 16;
		sum  = sum - longint'(term);
		term = ((term * fr) >> 16) / 2;
		sum  = sum + longint'(term);
		term = ((term * fr) >> 16) / 3;
		sum  = sum - longint'(term);
		term = ((term * fr) >> 16) / 4;
		sum  = sum + longint'(term);
		term = ((term * fr) >> 16) / 5;
		sum  = sum - longint'(term);
		term = ((term * fr) >> 16) / 6;
		sum  = sum + longint'(term);
		term = ((term * fr) >> 16) / 7;
		sum  = sum - longint'(term);
		term = ((term * fr) >> 16) / 8;
		sum  = sum + longint'(term);
		term = ((term * fr) >> 16) / 9;
		sum  = sum - longint'(term);
		term = ((term * fr) >> 16) / 10;
		sum  = sum + longint'(term);
		v = longint'(unsigned'(sum));
		for (i = 0; i < whole; i++)
			v = (v * EINV_Q30) >> 30;
		return DENS_W'((v + (64'd1 << 13)) >> 14);
	endfunction

endpackage

[rtl/rbms_div.sv]
module rbms_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rbms_pkg::IDX_W-1:0]    idx,
	input  logic [rbms_pkg::SIZE_W-1:0]   size,
	output logic [rbms_pkg::QUO_W-1:0]    quo
);
	import rbms_pkg::*;

	// dividend is idx << LOW_W, one quotient bit per stage
	localparam int LOW_W = QUO_W - IDX_W;

	logic [IDX_W-1:0]  idx_s [QUO_W];
	logic [SIZE_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0]  quo_s [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stg
		localparam int B = QUO_W - 1 - i;
		logic [IDX_W-1:0]  idx_in;
		logic [SIZE_W-1:0] rem_in;
		logic [QUO_W-1:0]  quo_in;
		logic              nb;
		logic [SIZE_W:0]   sh;
		logic              ge;

		if (i == 0) begin : g_first
			assign idx_in = idx;
			assign rem_in = '0;
			assign quo_in = '0;
		end else begin : g_next
			assign idx_in = idx_s[i-1];
			assign rem_in = rem_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		if (B >= LOW_W) begin : g_bit
			assign nb = idx_in[B-LOW_W];
		end else begin : g_zero
			assign nb = 1'b0;
		end

		assign sh = {rem_in, nb};
		assign ge = (sh >= {1'b0, size});

		always_ff @(posedge clk) begin
			if (en) begin
				idx_s[i] <= idx_in;
				rem_s[i] <= ge ? SIZE_W'(sh - {1'b0, size}) : sh[SIZE_W-1:0];
				quo_s[i] <= {quo_in[QUO_W-2:0], ge};
			end
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

[rtl/rbms_radius.sv]
module rbms_radius (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rbms_pkg::QUO_W-1:0]    quo_x,
	input  logic [rbms_pkg::QUO_W-1:0]    quo_y,
	output logic [rbms_pkg::R2_W-1:0]     r2
);
	import rbms_pkg::*;

	localparam logic [QUO_W-1:0] HALF = QUO_W'(65536);
	localparam logic [QUO_W-1:0] CMAX = QUO_W'(131071);

	logic [COORD_W-1:0] ax_s1, ay_s1;
	logic [R2_W-1:0]    sqx_s2, sqy_s2;
	logic [R2_W-1:0]    r2_s3;
	logic [2*COORD_W-1:0] px, py;
	logic [R2_W:0]      sum;

	// |q - 65536| with the upper coordinate saturation
	function automatic logic [COORD_W-1:0] mag(input logic [QUO_W-1:0] q);
		if (q < HALF)
			return COORD_W'(HALF - q);
		else if ((q - HALF) > CMAX)
			return '1;
		else
			return COORD_W'(q - HALF);
	endfunction

	assign px  = ax_s1 * ax_s1;
	assign py  = ay_s1 * ay_s1;
	assign sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= mag(quo_x);
			ay_s1  <= mag(quo_y);
			sqx_s2 <= px[2*COORD_W-1:16];
			sqy_s2 <= py[2*COORD_W-1:16];
			r2_s3  <= sum[R2_W] ? '1 : sum[R2_W-1:0];
		end
	end

	assign r2 = r2_s3;

endmodule

[rtl/rbms_kernel.sv]
module rbms_kernel #(
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                        clk,
	input  logic                        en,
	input  rbms_pkg::kind_t             kind,
	input  logic [rbms_pkg::R2_W-1:0]   r2,
	output logic [rbms_pkg::OUT_W-1:0]  density
);
	import rbms_pkg::*;

	localparam int D      = EXP_TABLE_DEPTH;
	localparam int DW     = $clog2(D + 1);
	localparam int PW     = R2_W + DW;
	localparam int KW     = PW - 16;
	localparam int SQ_STG = 17;
	localparam int G_DLY  = SQ_STG + 3 - 4;
	localparam int F_DLY  = SQ_STG + 3;

	// gaussian table, entry k at t = k * 100 / (9 * depth)
	logic [DENS_W-1:0] etab [D+1];
	for (genvar k = 0; k <= D; k++) begin : g_etab
		localparam longint unsigned TK = (64'(k) * 64'd6553600) / (64'd9 * 64'(D));
		assign etab[k] = exp_neg_q16(TK);
	end

	// unit-disc flag travels alongside
	logic unit_s [F_DLY];
	logic unit_in;
	assign unit_in = (r2 <= R2_W'(65536));

	always_ff @(posedge clk) begin
		if (en) begin
			unit_s[0] <= unit_in;
			for (int i = 1; i < F_DLY; i++)
				unit_s[i] <= unit_s[i-1];
		end
	end

	// gaussian path
	logic [PW-1:0]     p_s1;
	logic [PW-1:0]     pfull;
	logic [KW-1:0]     kpos;
	logic [DW-1:0]     kidx;
	logic [DENS_W-1:0] e0, e1;
	logic [DENS_W-1:0] ge0_s2, gd_s2;
	logic [15:0]       gw_s2;
	logic              gz_s2;
	logic [DENS_W-1:0] ge0_s3;
	logic [DENS_W+15:0] gm_s3;
	logic              gz_s3;
	logic [DENS_W-1:0] g_s4;
	logic [DENS_W-1:0] g_dly [G_DLY];

	assign pfull = PW'({{DW{1'b0}}, r2} * PW'(D));
	assign kpos  = p_s1[PW-1:16];
	assign kidx  = kpos[DW-1:0];
	assign e0    = etab[kidx];
	assign e1    = etab[DW'(kidx + 1'b1)];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1   <= pfull >> 1;
			gz_s2  <= (kpos >= KW'(D));
			ge0_s2 <= e0;
			gd_s2  <= (e1 > e0) ? '0 : e0 - e1;
			gw_s2  <= p_s1[15:0];
			gm_s3  <= gd_s2 * gw_s2;
			ge0_s3 <= ge0_s2;
			gz_s3  <= gz_s2;
			g_s4   <= gz_s3 ? '0 : ge0_s3 - gm_s3[DENS_W+15:16];
			g_dly[0] <= g_s4;
			for (int i = 1; i < G_DLY; i++)
				g_dly[i] <= g_dly[i-1];
		end
	end

	// square root of r2 << 16, one root bit per stage
	logic [32:0]       rem_s  [SQ_STG];
	logic [DENS_W-1:0] root_s [SQ_STG];

	for (genvar i = 0; i < SQ_STG; i++) begin : g_sqrt
		localparam int J = SQ_STG - 1 - i;
		logic [32:0]       rem_in;
		logic [DENS_W-1:0] root_in;
		logic [33:0]       inc;
		logic              ge;

		if (i == 0) begin : g_first
			assign rem_in  = unit_in ? {r2[16:0], 16'b0} : '0;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
		end

		assign inc = (34'(root_in) << (J + 1)) | (34'd1 << (2 * J));
		assign ge  = ({1'b0, rem_in} >= inc);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? 33'({1'b0, rem_in} - inc) : rem_in;
				root_s[i] <= ge ? (root_in | (DENS_W'(1) << J)) : root_in;
			end
		end
	end

	// parzen cubic
	logic [DENS_W-1:0]   rt, pd;
	logic                pbig;
	logic [DENS_W-1:0]   pa;
	logic [2*DENS_W-1:0] pa2;
	logic [30:0]         sq_s18;
	logic [DENS_W-1:0]   d_s18;
	logic                big_s18;
	logic [47:0]         prod_s19;
	logic                big_s19;
	logic [50:0]         six;
	logic [DENS_W-1:0]   pz_val;
	logic [DENS_W-1:0]   pz_s20;

	assign rt   = root_s[SQ_STG-1];
	assign pd   = Q16_ONE - rt;
	assign pbig = (rt >= DENS_W'(32768));
	assign pa   = pbig ? pd : rt;
	assign pa2  = pa * pa;
	assign six  = {1'b0, prod_s19, 2'b0} + {2'b0, prod_s19, 1'b0};
	assign pz_val = big_s19 ? DENS_W'(prod_s19 >> 31) : Q16_ONE - DENS_W'(six >> 32);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s18   <= pa2[30:0];
			d_s18    <= pd;
			big_s18  <= pbig;
			prod_s19 <= sq_s18 * d_s18;
			big_s19  <= big_s18;
			pz_s20   <= unit_s[F_DLY-2] ? pz_val : '0;
		end
	end

	// kernel select and scale to 8 bits
	logic [DENS_W-1:0] dsel;
	logic [24:0]       scaled;
	logic [OUT_W-1:0]  density_s21;

	always_comb begin
		unique case (kind)
			KIND_GAUSS:  dsel = g_dly[G_DLY-1];
			KIND_PARZEN: dsel = pz_s20;
			KIND_CIRCLE: dsel = unit_s[F_DLY-1] ? Q16_ONE : '0;
			default:     dsel = '0;
		endcase
	end

	assign scaled = {dsel, 8'b0} - 25'(dsel) + 25'd32768;

	always_ff @(posedge clk) begin
		if (en)
			density_s21 <= scaled[23:16];
	end

	assign density = density_s21;

endmodule

[rtl/radial_brush_mask_sampler_top.sv]
// channel | dir | handshake               | payload
// s       | in  | s_tvalid / s_tready     | s_tdata: col [7:0], row [15:8]
// m       | out | m_tvalid / m_tready     | m_tdata: density [7:0]
// cfg     | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data (kind [1:0] or size [8:0])
//
// one pixel per clock unless m stalls; the data passes the 25-step coordinate divider
// and the 17-step square root pipeline feeding the kernel math
// arst_n clears the stage valid bits and the config registers (gaussian, size 1)
// a stall on m freezes the whole pipeline; s_tready follows the output stage
// cfg_ready is always high
`include "radial_brush_mask_sampler_top_assert.svh"

module radial_brush_mask_sampler_top #(
	parameter int MAX_SIZE        = 256,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [15:0]                  s_tdata,   // col [7:0], row [15:8]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,   // density [7:0]
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  rbms_pkg::cfg_idx_t           cfg_index,
	input  logic [rbms_pkg::SIZE_W-1:0]  cfg_data
);
	import rbms_pkg::*;

	kind_t              kind_q;
	logic [SIZE_W-1:0]  size_q;
	logic [SIZE_W-1:0]  size_eff;
	logic [PIPE_LAT-1:0] vld_q;
	logic               adv;
	logic [QUO_W-1:0]   quo_x, quo_y;
	logic [R2_W-1:0]    r2;
	logic [OUT_W-1:0]   density;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_GAUSS;
			size_q <= SIZE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KIND: kind_q <= kind_t'(cfg_data[1:0]);
				CFG_SIZE: size_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		if (size_q == '0)
			size_eff = SIZE_W'(1);
		else if (32'(size_q) > MAX_SIZE)
			size_eff = SIZE_W'(MAX_SIZE);
		else
			size_eff = size_q;
	end

	// whole pipeline moves together
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[PIPE_LAT-2:0], s_tvalid};
	end

	rbms_div u_div_x (
		.clk  (clk),
		.en   (adv),
		.idx  (s_tdata[7:0]),
		.size (size_eff),
		.quo  (quo_x)
	);

	rbms_div u_div_y (
		.clk  (clk),
		.en   (adv),
		.idx  (s_tdata[15:8]),
		.size (size_eff),
		.quo  (quo_y)
	);

	rbms_radius u_radius (
		.clk   (clk),
		.en    (adv),
		.quo_x (quo_x),
		.quo_y (quo_y),
		.r2    (r2)
	);

	rbms_kernel #(
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_kernel (
		.clk     (clk),
		.en      (adv),
		.kind    (kind_q),
		.r2      (r2),
		.density (density)
	);

	assign m_tdata = density;

	`RBMS_ASSERT_RST(a_rst_empty, !arst_n |-> !m_tvalid)
	`RBMS_ASSERT(a_cfg_size, cfg_valid && cfg_ready && cfg_index == CFG_SIZE |=> size_q == $past(cfg_data))
	`RBMS_ASSERT(a_cfg_kind, cfg_valid && cfg_ready && cfg_index == CFG_KIND |=> kind_q == $past(kind_t'(cfg_data[1:0])))

endmodule

[tb/sv/radial_brush_mask_sampler_top_tb.sv]
`timescale 1ns / 100ps

class mask_density_scoreboard;
	bit [1:0]   kind;
	bit [8:0]   size;
	bit [7:0]   density_q[$];
	int         errors;

	function new();
		kind = rbms_pkg::KIND_GAUSS;
		size = 9'd1;
		errors = 0;
	endfunction

	function longint unsigned exp_neg(longint unsigned t);
		longint unsigned whole, fr, term, v;
		longint sum;
		whole = t >> 16;
		fr = t & 64'hFFFF;
		term = 64'd1 << 30;
		sum = longint'(term);
		if (whole >= 24)
			return 0;
		for (int i = 1; i <= 10; i++) begin
			term = (term * fr) / (64'd65536 * i);
			if (i % 2)
				sum -= longint'(term);
			else
				sum += longint'(term);
		end
		v = longint'(sum);
		for (longint unsigned i = 0; i < whole; i++)
			v = (v * rbms_pkg::EINV_Q30) >> 30;
		return (v + 64'd8192) >> 14;
	endfunction

	function longint unsigned gauss_at(longint unsigned k);
		return exp_neg((k * 100 * 65536) / (9 * 256));
	endfunction

	function longint unsigned root(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function longint coord(longint unsigned idx, longint unsigned s);
		longint c;
		c = longint'((idx * 131072) / s) - 65536;
		if (c > 131071)
			c = 131071;
		if (c < -131072)
			c = -131072;
		return c;
	endfunction

	function longint unsigned kernel(longint unsigned r2);
		longint unsigned p, k, w, e0, e1, r, d;
		case (kind)
			rbms_pkg::KIND_GAUSS: begin
				p = (r2 * 256) >> 1;
				k = p >> 16;
				w = p & 64'hFFFF;
				if (k >= 256)
					return 0;
				e0 = gauss_at(k);
				e1 = gauss_at(k + 1);
				if (e1 > e0)
					e1 = e0;
				return e0 - (((e0 - e1) * w) >> 16);
			end
			rbms_pkg::KIND_PARZEN: begin
				if (r2 > 65536)
					return 0;
				r = root(r2 << 16);
				if (r > 65536)
					r = 65536;
				d = 65536 - r;
				if (r >= 32768)
					return (2 * d * d * d) >> 32;
				return 65536 - ((6 * r * r * d) >> 32);
			end
			rbms_pkg::KIND_CIRCLE:
				return (r2 <= 65536) ? 65536 : 0;
			default:
				return 0;
		endcase
	endfunction

	function void note_pixel(bit [7:0] col, bit [7:0] row);
		longint unsigned s, ax, ay, r2, d;
		longint x, y;
		s = size;
		if (s == 0)
			s = 1;
		if (s > 256)
			s = 256;
		x = coord(col, s);
		y = coord(row, s);
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		r2 = ((ax * ax) >> 16) + ((ay * ay) >> 16);
		if (r2 > 262143)
			r2 = 262143;
		d = kernel(r2);
		if (d > 65536)
			d = 65536;
		density_q.push_back(8'((d * 255 + 32768) >> 16));
	endfunction

	function void check_density(bit [7:0] got);
		bit [7:0] want;
		if (density_q.size() == 0) begin
			$display("%0t: unexpected density transfer, expected none, actual %0d", $time, got);
			errors++;
			return;
		end
		want = density_q.pop_front();
		if (want !== got) begin
			$display("%0t: density mismatch, expected %0d, actual %0d", $time, want, got);
			errors++;
		end
	endfunction
endclass

module radial_brush_mask_sampler_top_tb;
	import rbms_pkg::*;

	logic        clk;
	logic        arst_n = 1'b1;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;    // col [7:0], row [15:8]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;    // density [7:0]
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_idx_t    cfg_index;
	logic [8:0]  cfg_data;

	mask_density_scoreboard sb = new();
	bit  stalls_on;
	int  cycles;

	radial_brush_mask_sampler_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		cfg_valid = 0;
		cfg_index = CFG_KIND;
		cfg_data = '0;
		// clean falling edge so the async reset is seen
		#1 arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("radial_brush_mask_sampler_top verification failed");
			$finish;
		end
	end
	initial cycles = 0;

	// result side
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = stalls_on ? $urandom_range(0, 3) : 0;
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_density(m_tdata);
		end
	end

	task automatic send_pixel(bit [7:0] col, bit [7:0] row);
		int gap;
		gap = stalls_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {row, col};
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(col, row);
	endtask

	// only called with the pipeline drained
	task automatic write_reg(cfg_idx_t idx, bit [8:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_KIND)
			sb.kind = val[1:0];
		else
			sb.size = val;
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.density_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic run_phase(bit [1:0] kind, bit [8:0] size, int n);
		int lim;
		drain();
		write_reg(CFG_KIND, 9'(kind));
		write_reg(CFG_SIZE, size);
		stalls_on = $urandom_range(0, 3) != 0;
		lim = (size == 0) ? 1 : (size > 256 ? 256 : size);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			else
				send_pixel(8'($urandom_range(0, lim - 1)), 8'($urandom_range(0, lim - 1)));
		end
	endtask

	initial begin
		bit [1:0] kinds[4] = '{KIND_GAUSS, KIND_PARZEN, KIND_CIRCLE, KIND_NONE};
		@(posedge arst_n);
		@(posedge clk);
		// reset defaults first
		stalls_on = 0;
		send_pixel(0, 0);
		send_pixel(255, 255);
		foreach (kinds[i]) begin
			drain();
			write_reg(CFG_KIND, 9'(kinds[i]));
			write_reg(CFG_SIZE, 9'd256);
			send_pixel(0, 0);
			send_pixel(128, 128);
			send_pixel(255, 0);
			send_pixel(0, 255);
			send_pixel(255, 255);
			send_pixel(170, 128);
		end
		run_phase(KIND_GAUSS, 9'd256, 150);
		run_phase(KIND_PARZEN, 9'd256, 150);
		run_phase(KIND_CIRCLE, 9'd256, 150);
		run_phase(KIND_PARZEN, 9'd0, 40);
		run_phase(KIND_GAUSS, 9'd511, 100);
		run_phase(KIND_CIRCLE, 9'd1, 40);
		run_phase(KIND_NONE, 9'd16, 40);
		run_phase(KIND_GAUSS, 9'd37, 150);
		run_phase(KIND_PARZEN, 9'd100, 150);
		run_phase(KIND_CIRCLE, 9'd7, 100);
		run_phase(KIND_GAUSS, 9'd2, 60);
		run_phase(KIND_PARZEN, 9'd255, 150);
		s_tvalid <= 0;
		while (sb.density_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("radial_brush_mask_sampler_top verification clean");
		else
			$display("radial_brush_mask_sampler_top verification failed");
		$finish;
	end
endmodule
